// ===== rtl/dcnls_pkg.sv =====
`timescale 1ns / 1ps
package dcnls_pkg;

    localparam int SMP_W  = 16;
    localparam int NW     = 13;
    localparam int SA_W   = 29;
    localparam int SAA_W  = 43;
    localparam int SAB_W  = 44;
    localparam int MAG_W  = 56;
    localparam int C_W    = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int Q_W    = 33;
    localparam int RT_W   = 34;
    localparam int SC_W   = 17;
    localparam int CFG_W  = 15;
    localparam int OUT_W  = 16;

    localparam logic [CFG_W-1:0] MIN_CORR_RST = 15'd22938;
    localparam logic [CFG_W-1:0] OFFSET_RST   = 15'd0;

    localparam logic REG_MIN_CORR = 1'b0;
    localparam logic REG_OFFSET   = 1'b1;

    typedef logic        [NW-1:0]     t_n;
    typedef logic signed [SA_W-1:0]   t_sa;
    typedef logic        [SAA_W-1:0]  t_saa;
    typedef logic signed [SAB_W-1:0]  t_sab;
    typedef logic        [MAG_W-1:0]  t_mag;
    typedef logic signed [SC_W-1:0]   t_score;

    typedef struct packed {
        logic ld_tpl;
        logic ld_win;
        logic lag_clr;
        logic lag_inc;
        logic acc_clr;
        logic tap_step;
        logic score_start;
        logic score_ch;
        logic best_upd;
        logic emit_full;
        logic emit_short;
    } t_cmd;

    typedef struct packed {
        logic win_fits;
        logic tap_done;
        logic lag_done;
        logic pipe_empty;
        logic score_done;
    } t_sts;

    function automatic t_mag mag57(input logic signed [C_W-1:0] v);
        logic signed [C_W-1:0] a;
        a = v[C_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/dcnls_ctrl.sv =====
`timescale 1ns / 1ps
module dcnls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_req_type,
    input  logic              i_last,
    input  dcnls_pkg::t_sts   i_sts,
    output dcnls_pkg::t_cmd   o_cmd,
    output logic              o_busy
);
    import dcnls_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAPS  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SC1   = 3'd3;
    localparam logic [2:0] ST_SC2   = 3'd4;
    localparam logic [2:0] ST_NEXT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       w_acc;

    assign o_busy = (r_state != ST_IDLE);
    assign w_acc  = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ld_tpl = w_acc && !i_req_type;
                o_cmd.ld_win = w_acc && i_req_type;
                if (w_acc && i_req_type && i_last) begin
                    if (i_sts.win_fits) begin
                        o_cmd.lag_clr = 1'b1;
                        o_cmd.acc_clr = 1'b1;
                        n_state       = ST_TAPS;
                    end else begin
                        o_cmd.emit_short = 1'b1;
                    end
                end
            end
            ST_TAPS: begin
                if (i_sts.tap_done) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.tap_step = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_cmd.score_start = 1'b1;
                    n_state           = ST_SC1;
                end
            end
            ST_SC1: begin
                if (i_sts.score_done) begin
                    o_cmd.best_upd    = 1'b1;
                    o_cmd.score_start = 1'b1;
                    o_cmd.score_ch    = 1'b1;
                    n_state           = ST_SC2;
                end
            end
            ST_SC2: begin
                o_cmd.score_ch = 1'b1;
                if (i_sts.score_done) begin
                    o_cmd.best_upd = 1'b1;
                    n_state        = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (i_sts.lag_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.lag_inc = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    n_state       = ST_TAPS;
                end
            end
            ST_DONE: begin
                o_cmd.emit_full = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dcnls_score.sv =====
`timescale 1ns / 1ps
module dcnls_score (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dcnls_pkg::t_n       i_n,
    input  dcnls_pkg::t_sa      i_sa,
    input  dcnls_pkg::t_saa     i_saa,
    input  dcnls_pkg::t_sab     i_sab,
    input  dcnls_pkg::t_sa      i_sb,
    input  dcnls_pkg::t_saa     i_sbb,
    output logic                o_done,
    output dcnls_pkg::t_score   o_score
);
    import dcnls_pkg::*;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_NSAB = 4'd1;
    localparam logic [3:0] PH_SASB = 4'd2;
    localparam logic [3:0] PH_NSAA = 4'd3;
    localparam logic [3:0] PH_SASA = 4'd4;
    localparam logic [3:0] PH_NSBB = 4'd5;
    localparam logic [3:0] PH_SBSB = 4'd6;
    localparam logic [3:0] PH_CC   = 4'd7;
    localparam logic [3:0] PH_VV   = 4'd8;
    localparam logic [3:0] PH_DIV  = 4'd9;
    localparam logic [3:0] PH_SQRT = 4'd10;

    localparam int MC_W = $clog2(MAG_W + 1);
    localparam int DC_W = $clog2(Q_W + 1);
    localparam logic [RT_W-1:0] SQ_ONE = RT_W'(1) << (Q_W - 1);

    logic [3:0]          r_ph;
    logic [3:0]          w_lp;
    logic [PROD_W-1:0]   r_ma, r_prod;
    logic [MAG_W-1:0]    r_mb;
    logic [MC_W-1:0]     r_mcnt;
    logic [MAG_W-1:0]    r_t1, r_va, r_vb;
    logic signed [C_W-1:0] r_c;
    logic [PROD_W-1:0]   r_d;
    logic [PROD_W:0]     r_rem;
    logic [Q_W-1:0]      r_q;
    logic [DC_W-1:0]     r_dcnt;
    logic [RT_W-1:0]     r_op, r_res, r_one;
    logic                r_done;
    t_score              r_score;

    logic [MAG_W-1:0]    w_a, w_b;
    logic signed [C_W-1:0] w_x, w_y;
    logic [MAG_W-1:0]    w_vb;
    logic [RT_W-1:0]     w_sum;
    logic [SC_W-1:0]     w_lo;
    logic [PROD_W:0]     w_dext;

    assign w_lp   = r_ph + 4'd1;
    assign w_x    = i_sab[SAB_W-1] ? -$signed({1'b0, r_t1}) : $signed({1'b0, r_t1});
    assign w_y    = (i_sa[SA_W-1] ^ i_sb[SA_W-1]) ? -$signed({1'b0, r_prod[MAG_W-1:0]})
                                                   : $signed({1'b0, r_prod[MAG_W-1:0]});
    assign w_vb   = r_t1 - r_prod[MAG_W-1:0];
    assign w_sum  = r_res + r_one;
    assign w_lo   = SC_W'((r_res + RT_W'(1)) >> 1);
    assign w_dext = {1'b0, r_d};

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (w_lp)
            PH_NSAB: begin
                w_a = MAG_W'(i_n);
                w_b = mag57(C_W'(i_sab));
            end
            PH_SASB: begin
                w_a = mag57(C_W'(i_sa));
                w_b = mag57(C_W'(i_sb));
            end
            PH_NSAA: begin
                w_a = MAG_W'(i_n);
                w_b = MAG_W'(i_saa);
            end
            PH_SASA: begin
                w_a = mag57(C_W'(i_sa));
                w_b = mag57(C_W'(i_sa));
            end
            PH_NSBB: begin
                w_a = MAG_W'(i_n);
                w_b = MAG_W'(i_sbb);
            end
            PH_SBSB: begin
                w_a = mag57(C_W'(i_sb));
                w_b = mag57(C_W'(i_sb));
            end
            PH_CC: begin
                w_a = mag57(r_c);
                w_b = mag57(r_c);
            end
            PH_VV: begin
                w_a = r_va;
                w_b = r_vb;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ma   <= PROD_W'(w_a);
                        r_mb   <= w_b;
                        r_prod <= '0;
                        r_mcnt <= MC_W'(MAG_W);
                        r_ph   <= w_lp;
                    end
                end
                PH_NSAB, PH_SASB, PH_NSAA, PH_SASA, PH_NSBB, PH_SBSB, PH_CC, PH_VV: begin
                    if (r_mcnt != '0) begin
                        if (r_mb[0]) begin
                            r_prod <= r_prod + r_ma;
                        end
                        r_ma   <= r_ma << 1;
                        r_mb   <= r_mb >> 1;
                        r_mcnt <= r_mcnt - MC_W'(1);
                    end else begin
                        r_ma   <= PROD_W'(w_a);
                        r_mb   <= w_b;
                        r_prod <= '0;
                        r_mcnt <= MC_W'(MAG_W);
                        r_ph   <= w_lp;
                        priority case (r_ph)
                            PH_NSAB, PH_NSAA, PH_NSBB: r_t1 <= r_prod[MAG_W-1:0];
                            PH_SASB: r_c  <= w_x - w_y;
                            PH_SASA: r_va <= r_t1 - r_prod[MAG_W-1:0];
                            PH_SBSB: begin
                                r_vb <= w_vb;
                                if (r_va == '0 || w_vb == '0) begin
                                    r_score <= '0;
                                    r_done  <= 1'b1;
                                    r_ph    <= PH_IDLE;
                                end
                            end
                            PH_CC: r_rem <= {1'b0, r_prod};
                            default: begin
                                r_d    <= r_prod;
                                r_q    <= '0;
                                r_dcnt <= DC_W'(Q_W);
                                r_ph   <= PH_DIV;
                            end
                        endcase
                    end
                end
                PH_DIV: begin
                    if (r_dcnt != '0) begin
                        if (r_rem >= w_dext) begin
                            r_rem <= (r_rem - w_dext) << 1;
                            r_q   <= {r_q[Q_W-2:0], 1'b1};
                        end else begin
                            r_rem <= r_rem << 1;
                            r_q   <= {r_q[Q_W-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - DC_W'(1);
                    end else begin
                        r_op  <= RT_W'(r_q);
                        r_res <= '0;
                        r_one <= SQ_ONE;
                        r_ph  <= PH_SQRT;
                    end
                end
                PH_SQRT: begin
                    if (r_one != '0) begin
                        if (r_op >= w_sum) begin
                            r_op  <= r_op - w_sum;
                            r_res <= (r_res >> 1) + r_one;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_one <= r_one >> 2;
                    end else begin
                        r_score <= r_c[C_W-1] ? -$signed(w_lo) : $signed(w_lo);
                        r_done  <= 1'b1;
                        r_ph    <= PH_IDLE;
                    end
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_score = r_score;

endmodule

// ===== rtl/dcnls_dp.sv =====
`timescale 1ns / 1ps
module dcnls_dp #(
    parameter int TEMPLATE_MAX = 2048,
    parameter int WINDOW_MAX   = 32768
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dcnls_pkg::t_cmd             i_cmd,
    output dcnls_pkg::t_sts             o_sts,
    input  logic                        i_last,
    input  logic [dcnls_pkg::SMP_W-1:0] i_sample_ch1,
    input  logic [dcnls_pkg::SMP_W-1:0] i_sample_ch2,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dcnls_pkg::CFG_W-1:0] i_cfg_data,
    output logic                        o_done,
    output logic                        o_search_valid,
    output logic [dcnls_pkg::OUT_W-1:0] o_delay_ch1,
    output logic [dcnls_pkg::OUT_W-1:0] o_score_ch1,
    output logic                        o_ok_ch1,
    output logic [dcnls_pkg::OUT_W-1:0] o_delay_ch2,
    output logic [dcnls_pkg::OUT_W-1:0] o_score_ch2,
    output logic                        o_ok_ch2,
    output logic [dcnls_pkg::CFG_W-1:0] o_delay_diff,
    output logic                        o_diff_valid
);
    import dcnls_pkg::*;

    localparam int TA_W = $clog2(TEMPLATE_MAX);
    localparam int TC_W = $clog2(TEMPLATE_MAX + 1);
    localparam int WA_W = $clog2(WINDOW_MAX);
    localparam int WC_W = $clog2(WINDOW_MAX + 1);
    localparam int AS_W = (WC_W > TC_W) ? WC_W : TC_W;

    logic signed [SMP_W-1:0] r_tmem [TEMPLATE_MAX];
    logic signed [SMP_W-1:0] r_wmem1 [WINDOW_MAX];
    logic signed [SMP_W-1:0] r_wmem2 [WINDOW_MAX];

    logic [CFG_W-1:0] r_min_corr, r_offset;
    logic [TC_W-1:0]  r_tcount, r_tap;
    logic             r_closed;
    logic [WC_W-1:0]  r_wcount, r_lag;
    t_sa              r_sb;
    t_saa             r_sbb;

    logic [TC_W-1:0]  w_tc_eff;
    t_sa              w_sb_eff;
    t_saa             w_sbb_eff;
    logic             w_twr, w_wwr;
    logic [WC_W-1:0]  w_wc_next, w_max_lag;
    logic [AS_W-1:0]  w_raddr;
    logic signed [2*SMP_W-1:0] w_tsq;

    logic                    r_v1, r_v2;
    logic signed [SMP_W-1:0] r_tw, r_w1, r_w2;
    logic signed [SMP_W-1:0] r_a1, r_a2;
    logic signed [2*SMP_W-1:0] r_aa1, r_aa2, r_ab1, r_ab2;
    t_sa   r_sa1, r_sa2;
    t_saa  r_saa1, r_saa2;
    t_sab  r_sab1, r_sab2;

    logic   r_sel;
    logic   w_sel;
    logic   w_sdone;
    t_score w_score;
    t_score r_best1, r_best2;
    logic [WC_W-1:0] r_blag1, r_blag2;

    logic [SC_W-1:0] w_abs1, w_abs2;
    logic            w_ok1, w_ok2;
    logic [OUT_W:0]  w_d1, w_d2;
    logic signed [OUT_W+1:0] w_dd;
    logic [OUT_W:0]  w_adiff;

    assign w_tc_eff  = r_closed ? '0 : r_tcount;
    assign w_sb_eff  = r_closed ? '0 : r_sb;
    assign w_sbb_eff = r_closed ? '0 : r_sbb;
    assign w_twr     = i_cmd.ld_tpl && (w_tc_eff < TC_W'(TEMPLATE_MAX));
    assign w_wwr     = i_cmd.ld_win && (r_wcount < WC_W'(WINDOW_MAX));
    assign w_wc_next = (r_wcount < WC_W'(WINDOW_MAX)) ? r_wcount + WC_W'(1) : r_wcount;
    assign w_max_lag = r_wcount - WC_W'(r_tcount);
    assign w_raddr   = AS_W'(r_lag) + AS_W'(r_tap);
    assign w_tsq     = $signed(i_sample_ch1) * $signed(i_sample_ch1);
    assign w_sel     = i_cmd.score_start ? i_cmd.score_ch : r_sel;

    assign o_sts.win_fits   = (AS_W'(w_wc_next) >= AS_W'(r_tcount));
    assign o_sts.tap_done   = (r_tap == r_tcount);
    assign o_sts.lag_done   = (r_lag == w_max_lag);
    assign o_sts.pipe_empty = !r_v1 && !r_v2;
    assign o_sts.score_done = w_sdone;

    always_ff @(posedge i_clk) begin
        if (w_twr) begin
            r_tmem[w_tc_eff[TA_W-1:0]] <= i_sample_ch1;
        end
        r_tw <= r_tmem[r_tap[TA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wwr) begin
            r_wmem1[r_wcount[WA_W-1:0]] <= i_sample_ch1;
        end
        r_w1 <= r_wmem1[w_raddr[WA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wwr) begin
            r_wmem2[r_wcount[WA_W-1:0]] <= i_sample_ch2;
        end
        r_w2 <= r_wmem2[w_raddr[WA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_corr <= MIN_CORR_RST;
            r_offset   <= OFFSET_RST;
            r_tcount   <= '0;
            r_closed   <= 1'b0;
            r_sb       <= '0;
            r_sbb      <= '0;
            r_wcount   <= '0;
            r_lag      <= '0;
            r_tap      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_sel      <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MIN_CORR: r_min_corr <= i_cfg_data;
                    REG_OFFSET:   r_offset   <= i_cfg_data;
                endcase
            end
            if (i_cmd.ld_tpl) begin
                r_closed <= i_last;
                if (w_twr) begin
                    r_tcount <= w_tc_eff + TC_W'(1);
                    r_sb     <= w_sb_eff + SA_W'($signed(i_sample_ch1));
                    r_sbb    <= w_sbb_eff + SAA_W'(w_tsq);
                end else begin
                    r_tcount <= w_tc_eff;
                    r_sb     <= w_sb_eff;
                    r_sbb    <= w_sbb_eff;
                end
            end
            if (i_cmd.emit_short || i_cmd.emit_full) begin
                r_wcount <= '0;
            end else if (i_cmd.ld_win) begin
                r_wcount <= w_wc_next;
            end
            if (i_cmd.lag_clr) begin
                r_lag <= '0;
            end else if (i_cmd.lag_inc) begin
                r_lag <= r_lag + WC_W'(1);
            end
            if (i_cmd.acc_clr) begin
                r_tap <= '0;
            end else if (i_cmd.tap_step) begin
                r_tap <= r_tap + TC_W'(1);
            end
            if (i_cmd.score_start) begin
                r_sel <= i_cmd.score_ch;
            end
            r_v1   <= i_cmd.tap_step;
            r_v2   <= r_v1;
            o_done <= i_cmd.emit_short || i_cmd.emit_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_a1  <= r_w1;
            r_a2  <= r_w2;
            r_aa1 <= r_w1 * r_w1;
            r_aa2 <= r_w2 * r_w2;
            r_ab1 <= r_w1 * r_tw;
            r_ab2 <= r_w2 * r_tw;
        end
        if (i_cmd.acc_clr) begin
            r_sa1  <= '0;
            r_sa2  <= '0;
            r_saa1 <= '0;
            r_saa2 <= '0;
            r_sab1 <= '0;
            r_sab2 <= '0;
        end else if (r_v2) begin
            r_sa1  <= r_sa1 + SA_W'(r_a1);
            r_sa2  <= r_sa2 + SA_W'(r_a2);
            r_saa1 <= r_saa1 + SAA_W'($unsigned(r_aa1));
            r_saa2 <= r_saa2 + SAA_W'($unsigned(r_aa2));
            r_sab1 <= r_sab1 + SAB_W'(r_ab1);
            r_sab2 <= r_sab2 + SAB_W'(r_ab2);
        end
    end

    dcnls_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.score_start),
        .i_n     (NW'(r_tcount)),
        .i_sa    (w_sel ? r_sa2 : r_sa1),
        .i_saa   (w_sel ? r_saa2 : r_saa1),
        .i_sab   (w_sel ? r_sab2 : r_sab1),
        .i_sb    (r_sb),
        .i_sbb   (r_sbb),
        .o_done  (w_sdone),
        .o_score (w_score)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_upd) begin
            if (!r_sel) begin
                if (r_lag == '0 || w_score > r_best1) begin
                    r_best1 <= w_score;
                    r_blag1 <= r_lag;
                end
            end else begin
                if (r_lag == '0 || w_score > r_best2) begin
                    r_best2 <= w_score;
                    r_blag2 <= r_lag;
                end
            end
        end
    end

    assign w_abs1  = r_best1[SC_W-1] ? SC_W'(-r_best1) : SC_W'(r_best1);
    assign w_abs2  = r_best2[SC_W-1] ? SC_W'(-r_best2) : SC_W'(r_best2);
    assign w_ok1   = (w_abs1 >= SC_W'(r_min_corr));
    assign w_ok2   = (w_abs2 >= SC_W'(r_min_corr));
    assign w_d1    = w_ok1 ? (OUT_W + 1)'(r_offset) + (OUT_W + 1)'(r_blag1) : '0;
    assign w_d2    = w_ok2 ? (OUT_W + 1)'(r_offset) + (OUT_W + 1)'(r_blag2) : '0;
    assign w_dd    = $signed({2'b00, w_d1[OUT_W-1:0]}) - $signed({2'b00, w_d2[OUT_W-1:0]});
    assign w_adiff = w_dd[OUT_W+1] ? (OUT_W + 1)'(-w_dd) : (OUT_W + 1)'(w_dd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_short) begin
            o_search_valid <= 1'b0;
            o_delay_ch1    <= '0;
            o_score_ch1    <= '0;
            o_ok_ch1       <= 1'b0;
            o_delay_ch2    <= '0;
            o_score_ch2    <= '0;
            o_ok_ch2       <= 1'b0;
            o_delay_diff   <= '0;
            o_diff_valid   <= 1'b0;
        end else if (i_cmd.emit_full) begin
            o_search_valid <= 1'b1;
            o_delay_ch1    <= w_d1[OUT_W-1:0];
            o_score_ch1    <= (r_best1 > t_score'(32767)) ? OUT_W'(32767) : r_best1[OUT_W-1:0];
            o_ok_ch1       <= w_ok1;
            o_delay_ch2    <= w_d2[OUT_W-1:0];
            o_score_ch2    <= (r_best2 > t_score'(32767)) ? OUT_W'(32767) : r_best2[OUT_W-1:0];
            o_ok_ch2       <= w_ok2;
            o_delay_diff   <= (w_ok1 && w_ok2) ? w_adiff[CFG_W-1:0] : '0;
            o_diff_valid   <= w_ok1 && w_ok2;
        end
    end

endmodule

// ===== rtl/dual_channel_ncc_lag_search_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Transfer when            Payload
// sample    in         i_start && !o_busy       i_req_type, i_sample_ch1/2, i_last
// result    out        o_done (one cycle)       o_search_valid .. o_diff_valid
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// Template loads and window samples keep o_busy low. A final window sample
// of a window at least as long as the template (N taps, W samples) raises
// o_busy for a search over all W - N + 1 lags: each lag walks the N taps
// through the memory read and MAC pipeline, then the shared score unit
// (bit-serial multiplier, restoring divider, digit square root) runs once per
// channel, finishing early when a variance is zero. A short window reports
// in the next cycle. Reset is synchronous, active low. Results cannot be stalled.
module dual_channel_ncc_lag_search_unit #(
    parameter int TEMPLATE_MAX = 2048,
    parameter int WINDOW_MAX   = 32768
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [dcnls_pkg::SMP_W-1:0] i_sample_ch1,
    input  logic [dcnls_pkg::SMP_W-1:0] i_sample_ch2,
    input  logic                        i_last,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dcnls_pkg::CFG_W-1:0] i_cfg_data,
    output logic                        o_done,
    output logic                        o_search_valid,
    output logic [dcnls_pkg::OUT_W-1:0] o_delay_ch1,
    output logic [dcnls_pkg::OUT_W-1:0] o_score_ch1,
    output logic                        o_ok_ch1,
    output logic [dcnls_pkg::OUT_W-1:0] o_delay_ch2,
    output logic [dcnls_pkg::OUT_W-1:0] o_score_ch2,
    output logic                        o_ok_ch2,
    output logic [dcnls_pkg::CFG_W-1:0] o_delay_diff,
    output logic                        o_diff_valid
);
    import dcnls_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dcnls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_last     (i_last),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy)
    );

    dcnls_dp #(
        .TEMPLATE_MAX (TEMPLATE_MAX),
        .WINDOW_MAX   (WINDOW_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_last         (i_last),
        .i_sample_ch1   (i_sample_ch1),
        .i_sample_ch2   (i_sample_ch2),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_search_valid (o_search_valid),
        .o_delay_ch1    (o_delay_ch1),
        .o_score_ch1    (o_score_ch1),
        .o_ok_ch1       (o_ok_ch1),
        .o_delay_ch2    (o_delay_ch2),
        .o_score_ch2    (o_score_ch2),
        .o_ok_ch2       (o_ok_ch2),
        .o_delay_diff   (o_delay_diff),
        .o_diff_valid   (o_diff_valid)
    );

endmodule

// ===== rtl/dcnls_checker.sv =====
`timescale 1ns / 1ps
module dcnls_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        i_req_type,
    input logic                        i_last,
    input logic                        o_done,
    input logic                        o_search_valid,
    input logic [dcnls_pkg::OUT_W-1:0] o_delay_ch1,
    input logic                        o_ok_ch1,
    input logic                        o_ok_ch2,
    input logic                        o_diff_valid
);
    import dcnls_pkg::*;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && i_req_type && i_last))
        else $error("search without final window sample");

    a_diff_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_diff_valid) |-> (o_ok_ch1 && o_ok_ch2))
        else $error("difference flagged without both channels");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_search_valid) |-> (!o_ok_ch1 && !o_ok_ch2 && o_delay_ch1 == '0))
        else $error("short window result not cleared");

endmodule

bind dual_channel_ncc_lag_search_unit dcnls_checker u_dcnls_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_req_type     (i_req_type),
    .i_last         (i_last),
    .o_done         (o_done),
    .o_search_valid (o_search_valid),
    .o_delay_ch1    (o_delay_ch1),
    .o_ok_ch1       (o_ok_ch1),
    .o_ok_ch2       (o_ok_ch2),
    .o_diff_valid   (o_diff_valid)
);
